// ===== rtl/core/rts_pulse_frame_decoder_top_macros.svh =====
// Assertion macros for the decoder top level.
// Define NO_ASSERTIONS to compile the checks out.
`ifndef RTS_PULSE_FRAME_DECODER_TOP_MACROS_SVH
`define RTS_PULSE_FRAME_DECODER_TOP_MACROS_SVH

`ifndef NO_ASSERTIONS

// Check that is held off while reset is asserted.
`define RPFD_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check that is also evaluated during reset.
`define RPFD_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`else

`define RPFD_ASSERT(lbl, prop, msg)
`define RPFD_ASSERT_RST(lbl, prop, msg)

`endif

`endif

// ===== rtl/core/rpfd_pkg.sv =====
`default_nettype none

package rpfd_pkg;

    // Frame geometry.
    localparam int FRAME_LEN = 7;
    localparam logic [2:0] LAST_BYTE = 3'd6;
    localparam logic [2:0] BIT_MSB = 3'd7;
    localparam logic [2:0] LAST_READ = 3'd6;

    // Pulse timing limits in microseconds.
    localparam logic [15:0] T_DATA_MIN = 16'd660;
    localparam logic [15:0] T_DATA_TRIM = 16'd800;
    localparam logic [15:0] T_SOFT_MIN = 16'd4200;
    localparam logic [15:0] T_SOFT_MAX = 16'd5200;
    localparam logic [15:0] T_HARD_MIN = 16'd1800;
    localparam logic [15:0] T_HARD_MAX = 16'd3200;
    localparam logic [15:0] T_ABORT = 16'd1800;
    localparam logic [15:0] T_HALVE = 16'd1100;
    localparam logic [15:0] T_SHORT = 16'd400;

    // Hardware sync counting.
    localparam logic [7:0] HARD_SYNC_MIN = 8'd4;
    localparam logic [7:0] HARD_SYNC_MAX = 8'd255;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_PENDING = 3'd0,
        ST_OK      = 3'd1,
        ST_BAD_CHK = 3'd2,
        ST_TIMING  = 3'd3,
        ST_BAD_CH  = 3'd4
    } t_status;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_LOOP,
        S_DECODE,
        S_DONE
    } t_fsm;

    // Per-channel receiver state, one memory word.
    typedef struct packed {
        logic       synced;
        logic [7:0] hard_sync_count;
        logic       soft_sync_seen;
        logic       half_bit_pending;
        logic [7:0] byte_accumulator;
        logic [2:0] bit_position;
        logic [2:0] byte_index;
    } t_chan_state;

    localparam t_chan_state CHAN_STATE_RST = '{
        synced:           1'b0,
        hard_sync_count:  8'd0,
        soft_sync_seen:   1'b0,
        half_bit_pending: 1'b0,
        byte_accumulator: 8'd0,
        bit_position:     3'd7,
        byte_index:       3'd0
    };

    // Write-back request to the channel state memory.
    typedef struct packed {
        logic        en;
        logic [3:0]  chan;
        t_chan_state data;
    } t_state_wr;

    // One result item.
    typedef struct packed {
        t_status     status;
        logic [3:0]  out_channel;
        logic [7:0]  key_byte;
        logic [3:0]  command;
        logic [15:0] rolling_code;
        logic [15:0] address_low;
        logic [7:0]  address_high;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/rpfd_if.sv =====
`default_nettype none

// Pulse input channel.
interface rpfd_pulse_if;
    logic        valid;
    logic        ready;
    logic [3:0]  channel;
    logic        level;
    logic [15:0] pulse_us;

    modport source (output valid, channel, level, pulse_us, input ready);
    modport sink (input valid, channel, level, pulse_us, output ready);
endinterface

// Decoded result channel.
interface rpfd_frame_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [3:0]  out_channel;
    logic [7:0]  key_byte;
    logic [3:0]  command;
    logic [15:0] rolling_code;
    logic [15:0] address_low;
    logic [7:0]  address_high;

    modport source (
        output valid, status, out_channel, key_byte, command, rolling_code,
               address_low, address_high,
        input  ready
    );
    modport sink (
        input  valid, status, out_channel, key_byte, command, rolling_code,
               address_low, address_high,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/rpfd_state_mem.sv =====
`default_nettype none

module rpfd_state_mem
    import rpfd_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_rd_en,
    input  wire logic [3:0]  i_rd_chan,
    input  wire t_state_wr   i_wr,
    output t_chan_state      o_rd_data
);

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    t_chan_state               r_mem [CHANNELS];
    logic [CHANNELS-1:0]       r_valid;
    t_chan_state               r_rd_data;
    logic                      r_rd_hit;

    // Storage and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.chan[CH_AW-1:0]] <= i_wr.data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_chan[CH_AW-1:0]];
        end
    end

    // Written flags: an entry never written reads as the reset state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_rd_hit <= 1'b0;
        end else begin
            if (i_wr.en) begin
                r_valid[i_wr.chan[CH_AW-1:0]] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_hit <= r_valid[i_rd_chan[CH_AW-1:0]];
            end
        end
    end

    assign o_rd_data = r_rd_hit ? r_rd_data : CHAN_STATE_RST;

endmodule

`default_nettype wire

// ===== rtl/core/rpfd_frame_mem.sv =====
`default_nettype none

module rpfd_frame_mem
    import rpfd_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_wr_en,
    input  wire logic [$clog2(CHANNELS*FRAME_LEN)-1:0] i_wr_addr,
    input  wire logic [7:0]                           i_wr_data,
    input  wire logic                                 i_rd_en,
    input  wire logic [$clog2(CHANNELS*FRAME_LEN)-1:0] i_rd_addr,
    output logic [7:0]                                o_rd_data
);

    localparam int FB_DEPTH = CHANNELS * FRAME_LEN;

    logic [7:0] r_mem [FB_DEPTH];
    logic [7:0] r_rd_data;

    // Raw frame bytes, one write and one registered read per cycle.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

// ===== rtl/core/rts_pulse_frame_decoder_top.sv =====
// Sequence: a sync-phase or bad-channel pulse goes from the state read straight to the result;
// a data pulse runs its half-bit steps (one per cycle) and then writes the channel state back;
// the pulse that ends a frame writes the state back with its last step, then reads the frame back.
// Throughput: one pulse at a time; the next transfer is taken the cycle after the result
// enters the output register.
// Reset: synchronous, active low; channel state reads as its reset value at once.
`default_nettype none
`include "rts_pulse_frame_decoder_top_macros.svh"

module rts_pulse_frame_decoder_top
    import rpfd_pkg::*;
#(
    parameter int CHANNELS = 8
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    rpfd_pulse_if.sink    i_pulse,
    rpfd_frame_if.source  o_frame
);

    localparam int CH_AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int FB_AW = $clog2(CHANNELS * FRAME_LEN);
    localparam logic [4:0] CH_LIMIT = 5'(CHANNELS);

    t_fsm        r_fsm, n_fsm;
    logic [3:0]  r_ch, n_ch;
    logic        r_lvl, n_lvl;
    logic        r_bad, n_bad;
    logic [15:0] r_d, n_d;
    t_chan_state r_st, n_st;
    t_result     r_res, n_res;
    t_result     r_out, n_out;
    logic        r_outv, n_outv;
    logic [2:0]  r_dec_cnt, n_dec_cnt;
    logic [7:0]  r_prev, n_prev;
    logic [3:0]  r_chk, n_chk;
    logic [3:0]  r_rx_chk, n_rx_chk;
    logic [7:0]  r_b6, n_b6;

    logic             smem_rd_en;
    t_state_wr        smem_wr;
    t_chan_state      smem_rd_data;
    logic             fmem_wr_en;
    logic [FB_AW-1:0] fmem_wr_addr;
    logic [7:0]       fmem_wr_data;
    logic             fmem_rd_en;
    logic [FB_AW-1:0] fmem_rd_addr;
    logic [7:0]       fmem_rd_data;
    logic             in_xfer;

    // Location of one frame byte of a channel.
    function automatic logic [FB_AW-1:0] fb_addr(input logic [3:0] ch, input logic [2:0] idx);
        logic [CH_AW+2:0] base;
        base = {ch[CH_AW-1:0], 3'b000} - {3'b000, ch[CH_AW-1:0]};
        return FB_AW'(base + {{CH_AW{1'b0}}, idx});
    endfunction

    rpfd_state_mem #(
        .CHANNELS (CHANNELS)
    ) u_state_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (smem_rd_en),
        .i_rd_chan (n_ch),
        .i_wr      (smem_wr),
        .o_rd_data (smem_rd_data)
    );

    rpfd_frame_mem #(
        .CHANNELS (CHANNELS)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_wr_en   (fmem_wr_en),
        .i_wr_addr (fmem_wr_addr),
        .i_wr_data (fmem_wr_data),
        .i_rd_en   (fmem_rd_en),
        .i_rd_addr (fmem_rd_addr),
        .o_rd_data (fmem_rd_data)
    );

    assign i_pulse.ready = (r_fsm == S_IDLE);
    assign in_xfer = i_pulse.valid && i_pulse.ready;

    // Sequencer: next state, memory accesses and datapath updates.
    always_comb begin
        t_chan_state ws;
        logic [15:0] dt;
        logic [7:0]  fb;
        logic [7:0]  p;
        logic [7:0]  q;
        logic [7:0]  p6;
        logic [3:0]  chk;
        logic [2:0]  idx;

        n_fsm     = r_fsm;
        n_ch      = r_ch;
        n_lvl     = r_lvl;
        n_bad     = r_bad;
        n_d       = r_d;
        n_st      = r_st;
        n_res     = r_res;
        n_dec_cnt = r_dec_cnt;
        n_prev    = r_prev;
        n_chk     = r_chk;
        n_rx_chk  = r_rx_chk;
        n_b6      = r_b6;
        n_out     = r_out;
        n_outv    = r_outv && !o_frame.ready;

        smem_rd_en   = 1'b0;
        smem_wr.en   = 1'b0;
        smem_wr.chan = r_ch;
        smem_wr.data = r_st;
        fmem_wr_en   = 1'b0;
        fmem_wr_addr = fb_addr(r_ch, r_st.byte_index);
        fmem_wr_data = 8'd0;
        fmem_rd_en   = 1'b0;
        fmem_rd_addr = fb_addr(r_ch, r_dec_cnt);

        ws  = r_st;
        dt  = 16'd0;
        fb  = 8'd0;
        p   = 8'd0;
        q   = 8'd0;
        p6  = 8'd0;
        chk = r_chk;
        idx = r_dec_cnt - 3'd1;

        case (r_fsm)
            S_IDLE: begin
                // Capture the pulse and fetch its channel state.
                if (in_xfer) begin
                    n_ch       = i_pulse.channel;
                    n_lvl      = i_pulse.level;
                    n_d        = i_pulse.pulse_us;
                    n_bad      = ({1'b0, i_pulse.channel} >= CH_LIMIT);
                    smem_rd_en = !n_bad;
                    n_fsm      = S_READ;
                end
            end

            S_READ: begin
                n_res = '{status: ST_PENDING, out_channel: r_ch, default: '0};
                ws    = smem_rd_data;
                n_st  = ws;
                if (r_bad) begin
                    n_res.status = ST_BAD_CH;
                    n_fsm        = S_DONE;
                end else if (ws.synced) begin
                    n_fsm = S_LOOP;
                end else if (ws.soft_sync_seen && r_d >= T_DATA_MIN) begin
                    // Software sync done: this pulse opens the data.
                    dt = (r_d >= T_DATA_TRIM) ? r_d - T_DATA_TRIM : 16'd0;
                    ws.hard_sync_count = 8'd0;
                    ws.soft_sync_seen  = 1'b0;
                    ws.synced          = 1'b1;
                    n_st               = ws;
                    n_d                = dt;
                    if (dt < T_SHORT) begin
                        smem_wr.en   = 1'b1;
                        smem_wr.data = ws;
                        n_fsm        = S_DONE;
                    end else begin
                        n_fsm = S_LOOP;
                    end
                end else if (r_lvl && ws.hard_sync_count >= HARD_SYNC_MIN &&
                             r_d >= T_SOFT_MIN && r_d <= T_SOFT_MAX) begin
                    ws.soft_sync_seen = 1'b1;
                    smem_wr.en        = 1'b1;
                    smem_wr.data      = ws;
                    n_fsm             = S_DONE;
                end else if (r_d >= T_HARD_MIN && r_d <= T_HARD_MAX) begin
                    if (ws.hard_sync_count != HARD_SYNC_MAX) begin
                        ws.hard_sync_count = ws.hard_sync_count + 8'd1;
                    end
                    smem_wr.en   = 1'b1;
                    smem_wr.data = ws;
                    n_fsm        = S_DONE;
                end else begin
                    // Sync broken: start the search over.
                    ws.hard_sync_count = 8'd0;
                    ws.soft_sync_seen  = 1'b0;
                    smem_wr.en         = 1'b1;
                    smem_wr.data       = ws;
                    n_fsm              = S_DONE;
                end
            end

            S_LOOP: begin
                // One Manchester half-bit step per cycle.
                if (r_d == 16'd0) begin
                    smem_wr.en = 1'b1;
                    n_fsm      = S_DONE;
                end else if (r_st.byte_index != LAST_BYTE && r_d > T_ABORT) begin
                    ws.synced           = 1'b0;
                    ws.half_bit_pending = 1'b0;
                    ws.byte_accumulator = 8'd0;
                    ws.bit_position     = BIT_MSB;
                    ws.byte_index       = 3'd0;
                    smem_wr.en          = 1'b1;
                    smem_wr.data        = ws;
                    n_st                = ws;
                    n_res.status        = ST_TIMING;
                    n_fsm               = S_DONE;
                end else begin
                    n_d = (r_d > T_HALVE) ? (r_d >> 1) : 16'd0;
                    if (!ws.half_bit_pending) begin
                        ws.half_bit_pending = 1'b1;
                    end else begin
                        ws.half_bit_pending = 1'b0;
                        if (ws.bit_position != 3'd0) begin
                            ws.byte_accumulator = ws.byte_accumulator |
                                                  (8'(r_lvl) << ws.bit_position);
                            ws.bit_position     = ws.bit_position - 3'd1;
                        end else begin
                            // Byte complete: store it.
                            fb                  = ws.byte_accumulator | 8'(r_lvl);
                            fmem_wr_en          = 1'b1;
                            fmem_wr_data        = fb;
                            ws.byte_accumulator = 8'd0;
                            ws.bit_position     = BIT_MSB;
                            if (ws.byte_index == LAST_BYTE) begin
                                ws.synced     = 1'b0;
                                ws.byte_index = 3'd0;
                                smem_wr.en    = 1'b1;
                                smem_wr.data  = ws;
                                n_b6          = fb;
                                n_dec_cnt     = 3'd0;
                                n_chk         = 4'd0;
                                n_prev        = 8'd0;
                                n_fsm         = S_DECODE;
                            end else begin
                                ws.byte_index = ws.byte_index + 3'd1;
                            end
                        end
                    end
                    n_st = ws;
                end
            end

            S_DECODE: begin
                // Read bytes back one per cycle, de-chain and fold the checksum.
                if (r_dec_cnt != LAST_READ) begin
                    fmem_rd_en = 1'b1;
                end
                if (r_dec_cnt != 3'd0) begin
                    p      = (idx == 3'd0) ? fmem_rd_data : (fmem_rd_data ^ r_prev);
                    n_prev = fmem_rd_data;
                    q      = (idx == 3'd1) ? {p[7:4], 4'b0000} : p;
                    chk    = r_chk ^ q[3:0] ^ q[7:4];
                    n_chk  = chk;
                    case (idx)
                        3'd0: n_res.key_byte = p;
                        3'd1: begin
                            n_res.command = p[7:4];
                            n_rx_chk      = p[3:0];
                        end
                        3'd2: n_res.rolling_code[15:8] = p;
                        3'd3: n_res.rolling_code[7:0]  = p;
                        3'd4: n_res.address_low[7:0]   = p;
                        3'd5: n_res.address_low[15:8]  = p;
                        default: ;
                    endcase
                end
                if (r_dec_cnt == LAST_READ) begin
                    // Last byte comes from the register, chained to byte five.
                    p6                 = r_b6 ^ fmem_rd_data;
                    chk                = chk ^ p6[3:0] ^ p6[7:4];
                    n_res.address_high = p6;
                    n_res.status       = (chk == r_rx_chk) ? ST_OK : ST_BAD_CHK;
                    n_fsm              = S_DONE;
                end
                n_dec_cnt = r_dec_cnt + 3'd1;
            end

            S_DONE: begin
                // Hand the result to the output register once it is free.
                if (!r_outv || o_frame.ready) begin
                    n_out  = r_res;
                    n_outv = 1'b1;
                    n_fsm  = S_IDLE;
                end
            end

            default: begin
                n_fsm = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fsm <= S_IDLE;
        end else begin
            r_fsm <= n_fsm;
        end
    end

    // Datapath and output registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_outv <= 1'b0;
        end else begin
            r_outv <= n_outv;
        end
        r_ch      <= n_ch;
        r_lvl     <= n_lvl;
        r_bad     <= n_bad;
        r_d       <= n_d;
        r_st      <= n_st;
        r_res     <= n_res;
        r_out     <= n_out;
        r_dec_cnt <= n_dec_cnt;
        r_prev    <= n_prev;
        r_chk     <= n_chk;
        r_rx_chk  <= n_rx_chk;
        r_b6      <= n_b6;
    end

    // Output port.
    assign o_frame.valid        = r_outv;
    assign o_frame.status       = r_out.status;
    assign o_frame.out_channel  = r_out.out_channel;
    assign o_frame.key_byte     = r_out.key_byte;
    assign o_frame.command      = r_out.command;
    assign o_frame.rolling_code = r_out.rolling_code;
    assign o_frame.address_low  = r_out.address_low;
    assign o_frame.address_high = r_out.address_high;

    // Checks on the sequencer.
    `RPFD_ASSERT_RST(a_reset_clears,
        !i_rst_n |=> (!o_frame.valid && i_pulse.ready),
        "reset left a result or a busy sequencer")
    `RPFD_ASSERT(a_wb_phase,
        smem_wr.en |-> (r_fsm == S_READ || r_fsm == S_LOOP),
        "channel state written outside a pulse")
    `RPFD_ASSERT(a_fb_write,
        fmem_wr_en |-> (r_fsm == S_LOOP && !r_bad),
        "frame byte written outside the bit loop")
    `RPFD_ASSERT(a_bad_ch_empty,
        (o_frame.valid && o_frame.status == ST_BAD_CH) |->
            (o_frame.key_byte == 8'd0 && o_frame.rolling_code == 16'd0),
        "bad channel result carries frame data")

endmodule

`default_nettype wire
